// File: rtl/core/wwtl_pkg.sv
// ----------------------------------------------------------------------------
// wwtl_pkg
// Shared widths, codes, types and the font lookup for the word wrap layout.
// ----------------------------------------------------------------------------
`default_nettype none

package wwtl_pkg;

  localparam int MAX_ROW_DEF = 63;

  localparam int CODE_W      = 8;
  localparam int GLYPH_W     = 7;
  localparam int COL_W       = 6;
  localparam int ROW_W       = 7;   // one spare bit over the output row
  localparam int OUT_ROW_W   = 6;
  localparam int REV_W       = 16;
  localparam int SUM_W       = 8;   // column + separator + word length
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 24;

  localparam logic [COL_W-1:0] ROW_LENGTH_RST = 6'd40;
  localparam logic [COL_W-1:0] TOTAL_ROWS_RST = 6'd30;

  localparam logic [CODE_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CODE_W-1:0] CHAR_NEWLINE = 8'h0A;

  localparam logic KIND_GLYPH  = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_LENGTH    = 2'd0,
    REG_TOTAL_ROWS    = 2'd1,
    REG_REVEAL_ENABLE = 2'd2,
    REG_REVEAL_LIMIT  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [COL_W-1:0] row_length;
    logic [COL_W-1:0] total_rows;
    logic             reveal_enable;
    logic [REV_W-1:0] reveal_limit;
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    logic                 kind;
    logic [GLYPH_W-1:0]   glyph;
    logic [COL_W-1:0]     col;
    logic [OUT_ROW_W-1:0] row;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic               hit;
    logic [GLYPH_W-1:0] idx;
  } glyph_hit_t;

  // Font order: space ! ' , - . 0-9 ? A-Z a-z :
  function automatic glyph_hit_t glyph_lookup(input logic [CODE_W-1:0] code);
    glyph_hit_t g;
    g.hit = 1'b1;
    g.idx = '0;
    case (code) inside
      8'h20: g.idx = 7'd0;
      8'h21: g.idx = 7'd1;
      8'h27: g.idx = 7'd2;
      8'h2C: g.idx = 7'd3;
      8'h2D: g.idx = 7'd4;
      8'h2E: g.idx = 7'd5;
      [8'h30:8'h39]: g.idx = GLYPH_W'(code - 8'h30 + 8'd6);
      8'h3F: g.idx = 7'd16;
      [8'h41:8'h5A]: g.idx = GLYPH_W'(code - 8'h41 + 8'd17);
      [8'h61:8'h7A]: g.idx = GLYPH_W'(code - 8'h61 + 8'd43);
      8'h3A: g.idx = 7'd69;
      default: g.hit = 1'b0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/word_wrap_text_layout.sv
// ----------------------------------------------------------------------------
// word_wrap_text_layout
// Greedy word wrap of a character stream onto a character grid.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: char_code; tlast: end_of_text
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: glyph_index, column, row;
//                                             tuser: kind; tlast: last
// cfg       in   cfg_we (no wait)             cfg_index, cfg_wdata
//
// A character that is buffered or dropped is taken in S_IDLE. A flush (space,
// newline, end of text) places the word in S_CHECK, emits its glyphs in S_EMIT,
// closes the word in S_DONE and, at end of text, emits the marker in S_MARK.
// The glyph rate is set by the single read port of the word buffer RAM.
// Output stalls hold the sequencer; input is taken only when it is idle.
// rst is synchronous and clears layout state and registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module word_wrap_text_layout
  import wwtl_pkg::*;
#(
  parameter int MAX_ROW = MAX_ROW_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // slave side
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] char_code
  input  logic                  s_axis_tlast,   // end_of_text
  // master side
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [6:0] glyph_index, [12:7] column,
                                                // [18:13] row, [23:19] zero
  output logic                  m_axis_tuser,   // [0] kind
  output logic                  m_axis_tlast,   // last
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PAD_W = OUT_DATA_W - GLYPH_W - COL_W - OUT_ROW_W;

  cfg_t cfg;
  res_t res;
  logic slot_free;

  logic                 out_valid;
  logic                 out_kind;
  logic [GLYPH_W-1:0]   out_glyph;
  logic [COL_W-1:0]     out_col;
  logic [OUT_ROW_W-1:0] out_row;
  logic                 out_last;

  // Register file: write only; the sequencer uses the registered values directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_length    <= ROW_LENGTH_RST;
      cfg.total_rows    <= TOTAL_ROWS_RST;
      cfg.reveal_enable <= 1'b0;
      cfg.reveal_limit  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_LENGTH:    cfg.row_length    <= cfg_wdata[COL_W-1:0];
        REG_TOTAL_ROWS:    cfg.total_rows    <= cfg_wdata[COL_W-1:0];
        REG_REVEAL_ENABLE: cfg.reveal_enable <= cfg_wdata[0];
        REG_REVEAL_LIMIT:  cfg.reveal_limit  <= cfg_wdata[REV_W-1:0];
        default: ;
      endcase
    end
  end

  // Output slot is free when empty or being drained this cycle.
  assign slot_free = !out_valid || m_axis_tready;

  wwtl_seq #(
    .MAX_ROW(MAX_ROW)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_code  (s_axis_tdata[CODE_W-1:0]),
    .in_eot   (s_axis_tlast),
    .slot_free(slot_free),
    .res      (res)
  );

  // Output register: hold the word until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res.valid) begin
      out_kind  <= res.kind;
      out_glyph <= res.glyph;
      out_col   <= res.col;
      out_row   <= res.row;
      out_last  <= res.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_row, out_col, out_glyph};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

endmodule

`default_nettype wire

// File: rtl/core/wwtl_ram.sv
// ----------------------------------------------------------------------------
// wwtl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wwtl_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/wwtl_seq.sv
// ----------------------------------------------------------------------------
// wwtl_seq
// Word buffer and layout sequencer: buffer glyphs, place words, emit glyphs.
// ----------------------------------------------------------------------------
`default_nettype none

module wwtl_seq
  import wwtl_pkg::*;
#(
  parameter int MAX_ROW = MAX_ROW_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CODE_W-1:0] in_code,
  input  logic              in_eot,
  input  logic              slot_free,
  output res_t              res
);

  localparam int CNT_W = $clog2(MAX_ROW + 2);
  localparam int AW    = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_EMIT, S_DONE, S_MARK} state_t;

  state_t           state;
  logic [CNT_W-1:0] wc;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [REV_W-1:0] revealed;
  logic             halted;
  logic             eot_p;
  logic             nl_p;
  logic [AW-1:0]    idx;

  glyph_hit_t         hit;
  logic               accept;
  logic               is_flush;
  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [GLYPH_W-1:0] ram_rdata;
  logic [SUM_W-1:0]   wc_ext;
  logic [SUM_W-1:0]   len_ext;
  logic [SUM_W-1:0]   need;
  logic               too_long;
  logic               sep;
  logic               wrap;
  logic [ROW_W-1:0]   row_chk;
  logic               row_full;
  logic [REV_W-1:0]   rev_inc;
  logic               rev_stop;
  logic               rev_stop_next;
  logic               glyph_final;
  logic               fire;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign hit      = glyph_lookup(in_code);
  assign is_flush = (in_code == CHAR_SPACE) || (in_code == CHAR_NEWLINE);

  // placement checks for the buffered word
  assign wc_ext   = SUM_W'(wc);
  assign len_ext  = SUM_W'(cfg.row_length);
  assign too_long = (wc_ext > len_ext) || (wc > CNT_W'(MAX_ROW));
  assign sep      = (col != '0);
  assign need     = SUM_W'(col) + SUM_W'(sep) + wc_ext;
  assign wrap     = need > len_ext;
  assign row_chk  = wrap ? row + ROW_W'(1) : row;
  assign row_full = row_chk >= ROW_W'(cfg.total_rows);

  assign rev_inc       = (revealed == '1) ? revealed : revealed + REV_W'(1);
  assign rev_stop      = cfg.reveal_enable && (revealed >= cfg.reveal_limit);
  assign rev_stop_next = cfg.reveal_enable && (rev_inc >= cfg.reveal_limit);
  assign glyph_final   = (CNT_W'(idx) + CNT_W'(1)) == wc;
  assign fire          = res.valid && slot_free;

  assign ram_we = accept && !in_eot && !halted && !is_flush && hit.hit
                  && (wc < CNT_W'(MAX_ROW));
  assign ram_re = ((state == S_CHECK) && !too_long && !row_full && (wc != '0))
               || ((state == S_EMIT) && fire && !glyph_final);
  assign ram_raddr = (state == S_CHECK) ? '0 : idx + AW'(1);

  wwtl_ram #(
    .WIDTH (GLYPH_W),
    .DEPTH (MAX_ROW),
    .ADDR_W(AW)
  ) u_word_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wc[AW-1:0]),
    .wdata(hit.idx),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    res = '0;
    case (state)
      S_EMIT: begin
        res.valid = !rev_stop;
        res.kind  = KIND_GLYPH;
        res.glyph = ram_rdata;
        res.col   = col;
        res.row   = row[OUT_ROW_W-1:0];
        res.last  = !eot_p && (glyph_final || rev_stop_next);
      end
      S_MARK: begin
        res.valid = 1'b1;
        res.kind  = KIND_MARKER;
        res.last  = 1'b1;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wc       <= '0;
      col      <= '0;
      row      <= '0;
      revealed <= '0;
      halted   <= 1'b0;
      eot_p    <= 1'b0;
      nl_p     <= 1'b0;
      idx      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            eot_p <= in_eot;
            nl_p  <= !in_eot && (in_code == CHAR_NEWLINE);
            if (in_eot) begin
              state <= halted ? S_MARK : S_CHECK;
            end else if (!halted) begin
              if (is_flush) begin
                state <= S_CHECK;
              end else if (hit.hit && (wc <= CNT_W'(MAX_ROW))) begin
                wc <= wc + CNT_W'(1);
              end
            end
          end
        end
        S_CHECK: begin
          idx <= '0;
          if (too_long || row_full) begin
            halted <= 1'b1;
            state  <= eot_p ? S_MARK : S_IDLE;
          end else begin
            row <= row_chk;
            col <= wrap ? '0 : col + COL_W'(sep);
            if (!wrap && sep) begin
              revealed <= rev_inc;
            end
            state <= (wc == '0) ? S_DONE : S_EMIT;
          end
        end
        S_EMIT: begin
          if (rev_stop) begin
            halted <= 1'b1;
            state  <= eot_p ? S_MARK : S_IDLE;
          end else if (fire) begin
            col      <= col + COL_W'(1);
            revealed <= rev_inc;
            idx      <= idx + AW'(1);
            if (glyph_final) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          wc <= '0;
          if (nl_p) begin
            row      <= row + ROW_W'(1);
            col      <= '0;
            revealed <= rev_inc;
          end
          state <= eot_p ? S_MARK : S_IDLE;
        end
        S_MARK: begin
          if (fire) begin
            wc       <= '0;
            col      <= '0;
            row      <= '0;
            revealed <= '0;
            halted   <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_input_while_result: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !in_ready)
    else $error("input taken while a result is pending");

  a_glyph_in_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && fire) |-> (SUM_W'(col) < len_ext))
    else $error("glyph placed beyond row length");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    wc <= CNT_W'(MAX_ROW + 1))
    else $error("word count beyond saturation");

  a_marker_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK && fire) |=> (state == S_IDLE && wc == '0 && !halted))
    else $error("state not cleared after end of text");

  a_last_glyph_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && fire && res.last) |=> (state == S_DONE || rev_stop))
    else $error("glyphs continue after last flag");
`endif

endmodule

`default_nettype wire

// File: bench/word_wrap_text_layout_tb.sv
// ----------------------------------------------------------------------------
// word_wrap_text_layout_tb
// Self-checking bench for the greedy word wrap layout block. A short table
// of text drives the block through its corner cases. Random text then follows
// under a range of area sizes and reveal limits. Every output word is compared
// field by field with a layout predictor kept in step with accepted words.
// ----------------------------------------------------------------------------
`default_nettype none

module word_wrap_text_layout_tb;
  import wwtl_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int MAX_WORD      = MAX_ROW_DEF;
  localparam int SETTLE_CYCLES = 80;     // longest flush plus close and marker
  localparam int TARGET_CHARS  = 320;

  // One expected output word
  typedef struct packed {
    logic                 kind;
    logic [GLYPH_W-1:0]   glyph;
    logic [COL_W-1:0]     col;
    logic [OUT_ROW_W-1:0] row;
    logic                 last;
  } cell_t;

  typedef enum logic {SCRIPT_CHAR, SCRIPT_CFG} script_op_t;

  typedef struct {
    script_op_t       op;
    reg_idx_t         idx;
    logic [15:0]      value;
    logic [7:0]       code;
    logic             eot;
    bit               typed;
    cell_t            want;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Font order, glyph index is the position in this string
  string font_chars =
    " !',-.0123456789?ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz:";

  // Shadow of the text area registers and of the layout state
  cfg_t                area;
  logic [GLYPH_W-1:0]  word_glyphs [MAX_WORD];
  int                  word_len;
  int                  cur_col;
  int                  cur_row;
  int                  shown;
  bit                  lay_stopped;

  cell_t       step_cells[$];     // results of the word being predicted
  cell_t       awaited_cells[$];  // results still owed by the block
  script_row_t script[$];
  int          errors;
  int          text_chars_sent;
  bit          calm;              // no idling on either side while set

  word_wrap_text_layout dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Layout predictor
  // --------------------------------------------------------------------------

  function automatic int font_index(input logic [7:0] code);
    for (int i = 0; i < font_chars.len(); i++) begin
      if (font_chars[i] == code) return i;
    end
    return -1;
  endfunction

  function automatic void push_cell(input logic kind, input int glyph, input int col,
                                    input int row);
    cell_t c;
    c.kind  = kind;
    c.glyph = GLYPH_W'(glyph);
    c.col   = COL_W'(col);
    c.row   = OUT_ROW_W'(row);
    c.last  = 1'b0;
    step_cells.push_back(c);
  endfunction

  // Saturating count of revealed characters
  function automatic void reveal(input int n);
    shown = shown + n;
    if (shown > 65535) shown = 65535;
  endfunction

  function automatic void clear_layout();
    word_len    = 0;
    cur_col     = 0;
    cur_row     = 0;
    shown       = 0;
    lay_stopped = 1'b0;
  endfunction

  // Place the buffered word; a newline also moves to the next row
  function automatic void flush_word(input bit newline);
    int sep;
    int row_len;
    row_len = int'(area.row_length);
    // a word wider than a row can never be placed: stop until end of text
    if (word_len > row_len || word_len > MAX_WORD) begin
      lay_stopped = 1'b1;
      return;
    end
    sep = (cur_col > 0) ? 1 : 0;
    if (cur_col + sep + word_len > row_len) begin
      cur_row = cur_row + 1;
      cur_col = 0;
      sep     = 0;
    end
    if (cur_row >= int'(area.total_rows)) begin
      lay_stopped = 1'b1;
      return;
    end
    cur_col = cur_col + sep;
    reveal(sep);
    for (int i = 0; i < word_len; i++) begin
      // reveal limit cuts the word short
      if (area.reveal_enable && shown >= int'(area.reveal_limit)) begin
        lay_stopped = 1'b1;
        return;
      end
      push_cell(KIND_GLYPH, int'(word_glyphs[i]), cur_col, cur_row);
      cur_col = cur_col + 1;
      reveal(1);
    end
    word_len = 0;
    if (newline) begin
      cur_row = cur_row + 1;
      cur_col = 0;
      reveal(1);
    end
  endfunction

  // Work out the results of one accepted character word
  function automatic void wrap_char(input logic [7:0] code, input logic eot);
    int g;
    step_cells = {};
    if (eot) begin
      if (!lay_stopped) flush_word(1'b0);
      push_cell(KIND_MARKER, 0, 0, 0);
      clear_layout();
    end else if (!lay_stopped) begin
      if (code == CHAR_SPACE || code == CHAR_NEWLINE) begin
        flush_word(code == CHAR_NEWLINE);
      end else begin
        g = font_index(code);
        if (g >= 0) begin
          // hold at most a row's worth, but keep counting one past it
          if (word_len < MAX_WORD) word_glyphs[word_len] = GLYPH_W'(g);
          if (word_len <= MAX_WORD) word_len = word_len + 1;
        end
      end
    end
    if (step_cells.size() > 0) step_cells[step_cells.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // Offer one character word, wait for it to be taken, then log what it owes.
  // A typed row replaces the predicted results with the one written in the table.
  task automatic send_char(input logic [7:0] code, input logic eot, input bit typed,
                           input cell_t want);
    while (!calm && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    s_axis_tlast  <= eot;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    text_chars_sent++;
    wrap_char(code, eot);
    if (typed) awaited_cells.push_back(want);
    else foreach (step_cells[i]) awaited_cells.push_back(step_cells[i]);
  endtask

  // Drop valid and wait until the block has nothing left to say
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (awaited_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ROW_LENGTH:    area.row_length    = value[COL_W-1:0];
      REG_TOTAL_ROWS:    area.total_rows    = value[COL_W-1:0];
      REG_REVEAL_ENABLE: area.reveal_enable = value[0];
      REG_REVEAL_LIMIT:  area.reveal_limit  = value[REV_W-1:0];
      default: ;
    endcase
  endtask

  function automatic void add_char(input logic [7:0] code, input logic eot);
    script_row_t r;
    r.op = SCRIPT_CHAR; r.idx = REG_ROW_LENGTH; r.value = '0;
    r.code = code; r.eot = eot; r.typed = 1'b0; r.want = '0;
    script.push_back(r);
  endfunction

  function automatic void add_typed(input logic [7:0] code, input logic eot,
                                    input cell_t want);
    add_char(code, eot);
    script[script.size() - 1].typed = 1'b1;
    script[script.size() - 1].want  = want;
  endfunction

  function automatic void add_cfg(input reg_idx_t idx, input logic [15:0] value);
    script_row_t r;
    r.op = SCRIPT_CFG; r.idx = idx; r.value = value;
    r.code = '0; r.eot = 1'b0; r.typed = 1'b0; r.want = '0;
    script.push_back(r);
  endfunction

  // One stretch of random text: mostly plain words, some noise, some overlong
  task automatic run_text(input bit ends_text);
    int n_words;
    int len;
    int pick;
    logic [7:0] c;
    n_words = $urandom_range(4, 10);
    for (int w = 0; w < n_words; w++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80)      len = $urandom_range(1, 6);
      else if (pick < 95) len = $urandom_range(1, int'(area.row_length) + 2);
      else                len = $urandom_range(60, 70);   // around the buffer depth
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 99) < 5) c = 8'($urandom_range(0, 255));
        else c = font_chars[$urandom_range(1, 69)];
        send_char(c, 1'b0, 1'b0, '0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_char(CHAR_SPACE, 1'b0, 1'b0, '0);
      end else if (pick < 92) begin
        send_char(CHAR_NEWLINE, 1'b0, 1'b0, '0);
      end else begin
        send_char(CHAR_SPACE, 1'b0, 1'b0, '0);
        send_char(CHAR_SPACE, 1'b0, 1'b0, '0);
      end
    end
    // the byte that comes with end of text is ignored, so make it random
    if (ends_text) send_char(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
  endtask

  // Pick a text area, leaning on the extremes
  task automatic pick_area();
    logic [15:0] v;
    case ($urandom_range(0, 4))
      0: v = 16'd0;
      1: v = 16'd1;
      2: v = 16'd63;
      3: v = 16'($urandom_range(1, 63));
      default: v = 16'($urandom_range(4, 20));
    endcase
    write_reg(REG_ROW_LENGTH, v);
    case ($urandom_range(0, 4))
      0: v = 16'd0;
      1: v = 16'd1;
      2: v = 16'd63;
      3: v = 16'($urandom_range(1, 63));
      default: v = 16'($urandom_range(2, 10));
    endcase
    write_reg(REG_TOTAL_ROWS, v);
    write_reg(REG_REVEAL_ENABLE, 16'($urandom_range(0, 99) < 40));
    case ($urandom_range(0, 3))
      0: v = 16'd0;
      1: v = 16'hFFFF;
      2: v = 16'($urandom_range(0, 200));
      default: v = 16'($urandom_range(0, 65535));
    endcase
    write_reg(REG_REVEAL_LIMIT, v);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and the field-by-field check
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk) begin : sink
    cell_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 30);
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_cells.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = awaited_cells.pop_front();
          if (m_axis_tuser !== want.kind)
            report_mismatch($sformatf("kind %b, expected %b", m_axis_tuser, want.kind));
          if (m_axis_tdata[6:0] !== want.glyph)
            report_mismatch($sformatf("glyph %0d, expected %0d",
                                      m_axis_tdata[6:0], want.glyph));
          if (m_axis_tdata[12:7] !== want.col)
            report_mismatch($sformatf("column %0d, expected %0d",
                                      m_axis_tdata[12:7], want.col));
          if (m_axis_tdata[18:13] !== want.row)
            report_mismatch($sformatf("row %0d, expected %0d",
                                      m_axis_tdata[18:13], want.row));
          if (m_axis_tdata[23:19] !== '0)
            report_mismatch($sformatf("padding %b not zero", m_axis_tdata[23:19]));
          if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("last %b, expected %b", m_axis_tlast, want.last));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    int phase;
    errors          = 0;
    text_chars_sent = 0;
    calm            = 1'b0;
    area            = '{ROW_LENGTH_RST, TOTAL_ROWS_RST, 1'b0, 16'd0};
    clear_layout();

    // Directed table. Typed rows carry one result that is plain to see.
    // End of text straight after reset: marker only
    add_typed(8'h00, 1'b1, '{KIND_MARKER, 7'd0, 6'd0, 6'd0, 1'b1});
    // single digit at the top left corner
    add_char("0", 1'b0);
    add_typed(CHAR_SPACE, 1'b0, '{KIND_GLYPH, 7'd6, 6'd0, 6'd0, 1'b1});
    // font extremes with a byte outside the font in between, ended by newline
    add_char("A", 1'b0);
    add_char(8'hFF, 1'b0);
    add_char("z", 1'b0);
    add_char(":", 1'b0);
    add_char(CHAR_NEWLINE, 1'b0);
    // empty flush at column 0 places nothing
    add_char(CHAR_SPACE, 1'b0);
    add_char("q", 1'b0);
    add_char(CHAR_SPACE, 1'b0);
    // empty flush mid-row still advances the cursor by a separator
    add_char(CHAR_SPACE, 1'b0);
    add_typed(8'hA5, 1'b1, '{KIND_MARKER, 7'd0, 6'd0, 6'd0, 1'b1});
    // tiny area with a reveal limit
    add_cfg(REG_ROW_LENGTH, 16'd3);
    add_cfg(REG_TOTAL_ROWS, 16'd2);
    add_cfg(REG_REVEAL_ENABLE, 16'd1);
    add_cfg(REG_REVEAL_LIMIT, 16'd5);
    // word longer than a row: stop, then drop until end of text
    add_char("a", 1'b0);
    add_char("b", 1'b0);
    add_char("c", 1'b0);
    add_char("d", 1'b0);
    add_char(CHAR_SPACE, 1'b0);
    add_char("!", 1'b0);
    add_typed(8'h00, 1'b1, '{KIND_MARKER, 7'd0, 6'd0, 6'd0, 1'b1});
    // full row, newline, then the reveal limit cuts the next word
    add_char("a", 1'b0);
    add_char("b", 1'b0);
    add_char("c", 1'b0);
    add_char(CHAR_NEWLINE, 1'b0);
    add_char("x", 1'b0);
    add_char("y", 1'b0);
    add_char(8'h5A, 1'b1);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].op == SCRIPT_CFG) write_reg(script[i].idx, script[i].value);
      else send_char(script[i].code, script[i].eot, script[i].typed, script[i].want);
    end

    // Random text under changing areas; one phase runs with no idling at all.
    // A phase may stop mid-text so that the next area applies to a live layout.
    phase = 0;
    while (text_chars_sent < TARGET_CHARS) begin
      pick_area();
      calm = (phase == 2);
      run_text($urandom_range(0, 99) < 85);
      calm = 1'b0;
      phase++;
    end

    settle();
    if (errors == 0) $display("word_wrap_text_layout_tb passed");
    else $display("word_wrap_text_layout_tb failed");
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #(CLK_PERIOD * 400_000);
    $display("word_wrap_text_layout_tb failed");
    $finish;
  end

endmodule

`default_nettype wire
